// File: design/tanh_mlp_pkg.sv
// Shared types and constants for the one-input tanh MLP inference block.
// No dependencies; imported by one_input_tanh_mlp_inference.
`default_nettype none
package tanh_mlp_pkg;

    localparam int NEURONS   = 16;
    localparam int DEPTH     = 3 * NEURONS;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(NEURONS + 1);
    localparam int SUM_W     = 31 + $clog2(NEURONS);
    localparam int DIV_STEPS = 20;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    localparam logic [4:0] ACTIVE_RESET = 5'd15;

    // action codes
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_INFER = 1'b1;

    // weight slot codes
    localparam logic [1:0] SLOT_GAIN   = 2'd0;
    localparam logic [1:0] SLOT_BIAS   = 2'd1;
    localparam logic [1:0] SLOT_WOUT   = 2'd2;
    localparam logic [1:0] SLOT_UNUSED = 2'd3;

    // rational tanh coefficients, Q.12 scaled
    localparam logic [31:0] C378    = 32'(378 * 4096);
    localparam logic [31:0] C17325  = 32'(17325 * 4096);
    localparam logic [31:0] C135135 = 32'(135135 * 4096);
    localparam logic [33:0] C3150   = 34'(3150 * 4096);
    localparam logic [33:0] C62370  = 34'(62370 * 4096);
    localparam logic [33:0] C135135W = 34'(135135 * 4096);

    localparam logic [14:0] TANH_ONE = 15'd16384;

    localparam logic signed [SUM_W-1:0] Y_MAX = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] Y_MIN = -SUM_W'(32768);
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(8192);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD_GAIN,
        ST_MUL_XG,
        ST_ADD_BIAS,
        ST_ABS,
        ST_T,
        ST_SQ,
        ST_S,
        ST_INIT_AB,
        ST_MA1,
        ST_MA1W,
        ST_MA2,
        ST_MA2W,
        ST_MB1,
        ST_MB1W,
        ST_MB2,
        ST_MB2W,
        ST_MTA,
        ST_DIV_INIT,
        ST_DIV,
        ST_CLAMP,
        ST_ACC_MUL,
        ST_ACC,
        ST_ROUND,
        ST_EMIT
    } t_state;

endpackage
`default_nettype wire

// File: design/one_input_tanh_mlp_inference.sv
// One-input, one-hidden-layer tanh MLP: weight store, sequencer, shared multiplier
// and restoring divider. Depends on tanh_mlp_pkg.
//
// Usage:
//  - Input channel (i_in_valid / o_in_ready): one beat is either a weight load
//    (i_action = load: i_neuron_index, i_weight_slot, i_weight_value) or an
//    inference (i_action = infer: i_sample_x). Loads to slot 3 or to a neuron
//    beyond the store are dropped.
//  - Output channel (o_out_valid / i_out_ready): one beat per inference,
//    o_result_y in Q4.12 and o_saturated when the rounded sum was clipped.
//  - Config: i_cfg_we writes active_neurons from i_cfg_wdata; write only while idle.
//  - Timing: a load is written as it is accepted. An inference walks the active
//    neurons one by one: a saturated tanh (|u| >= 4) skips straight to the
//    accumulate step, while |u| < 4 runs the single shared 33x18 multiplier
//    stepping through the rational tanh polynomial and the 20-step bit-serial
//    divider producing each tanh quotient.
//  - o_in_ready is high only while the sequencer is idle; one item at a time.
//  - The result sits in an output register; the next item is accepted while it
//    waits. A following inference stalls at its final step until that beat is taken.
//  - Reset (synchronous, active low) returns the sequencer to idle, drops any
//    pending result and sets active_neurons to 15. The weight store is not
//    cleared: every weight used must be loaded first.
`default_nettype none
module one_input_tanh_mlp_inference (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic                i_action,
    input  wire logic [3:0]          i_neuron_index,
    input  wire logic [1:0]          i_weight_slot,
    input  wire logic signed [15:0]  i_weight_value,
    input  wire logic signed [15:0]  i_sample_x,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic signed [15:0]       o_result_y,
    output logic                     o_saturated,
    input  wire logic                i_cfg_we,
    input  wire logic [4:0]          i_cfg_wdata
);
    import tanh_mlp_pkg::*;

    // sequencer and control
    t_state r_state, n_state;
    logic [4:0]       r_active;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_idx;
    logic             r_out_valid;

    // datapath
    logic signed [15:0]      r_x;
    logic signed [50:0]      r_prod;
    logic signed [31:0]      r_u;
    logic                    r_neg;
    logic [25:0]             r_mag;
    logic [14:0]             r_t;
    logic [16:0]             r_s;
    logic [31:0]             r_a;
    logic [33:0]             r_b;
    logic [48:0]             r_num;
    logic [52:0]             r_div;
    logic [DIV_STEPS-1:0]    r_q;
    logic [DCNT_W-1:0]       r_dcnt;
    logic signed [15:0]      r_tanh;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [15:0]      r_y;
    logic                    r_sat;

    // weight store
    logic [15:0]       mem [DEPTH];
    logic signed [15:0] r_rd_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_en;

    // shared multiplier
    logic signed [32:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [50:0] mul_p;

    logic             in_acc;
    logic             can_emit;
    logic [CNT_W-1:0] count_cap;
    logic [CNT_W-1:0] idx_inc;
    logic [ADDR_W-1:0] rd_base;
    logic [31:0]      u_mag;
    logic             div_ge;
    logic [14:0]      q_clamp;

    assign in_acc   = i_in_valid && o_in_ready;
    assign can_emit = !r_out_valid || i_out_ready;
    assign idx_inc  = CNT_W'(r_idx + 1'b1);
    assign rd_base  = ADDR_W'(32'(r_idx) * 3);
    assign u_mag    = r_u[31] ? (~r_u + 32'd1) : r_u;
    assign div_ge   = {4'b0, r_num} >= r_div;
    assign q_clamp  = (r_q > DIV_STEPS'(TANH_ONE)) ? TANH_ONE : r_q[14:0];
    assign mul_p    = mul_a * mul_b;

    assign wr_addr = ADDR_W'(32'(i_neuron_index) * 3 + 32'(i_weight_slot));
    assign wr_en   = in_acc && (i_action == ACT_LOAD) && (i_weight_slot != SLOT_UNUSED)
                     && (32'(i_neuron_index) < NEURONS);

    always_comb begin
        if (32'(r_active) > NEURONS) begin
            count_cap = CNT_W'(NEURONS);
        end else begin
            count_cap = CNT_W'(r_active);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_action == ACT_INFER)) begin
                    n_state = (count_cap == '0) ? ST_ROUND : ST_RD_GAIN;
                end
            end
            ST_RD_GAIN:  n_state = ST_MUL_XG;
            ST_MUL_XG:   n_state = ST_ADD_BIAS;
            ST_ADD_BIAS: n_state = ST_ABS;
            ST_ABS:      n_state = (u_mag[31:26] != '0) ? ST_ACC_MUL : ST_T;
            ST_T:        n_state = ST_SQ;
            ST_SQ:       n_state = ST_S;
            ST_S:        n_state = ST_INIT_AB;
            ST_INIT_AB:  n_state = ST_MA1;
            ST_MA1:      n_state = ST_MA1W;
            ST_MA1W:     n_state = ST_MA2;
            ST_MA2:      n_state = ST_MA2W;
            ST_MA2W:     n_state = ST_MB1;
            ST_MB1:      n_state = ST_MB1W;
            ST_MB1W:     n_state = ST_MB2;
            ST_MB2:      n_state = ST_MB2W;
            ST_MB2W:     n_state = ST_MTA;
            ST_MTA:      n_state = ST_DIV_INIT;
            ST_DIV_INIT: n_state = ST_DIV;
            ST_DIV: begin
                if (r_dcnt == DCNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_CLAMP;
                end
            end
            ST_CLAMP:    n_state = ST_ACC_MUL;
            ST_ACC_MUL:  n_state = ST_ACC;
            ST_ACC:      n_state = (idx_inc == r_count) ? ST_ROUND : ST_RD_GAIN;
            ST_ROUND:    n_state = ST_EMIT;
            ST_EMIT: begin
                if (can_emit) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // outputs: ready, store reads, multiplier operands
    always_comb begin
        o_in_ready = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = rd_base;
        mul_a      = '0;
        mul_b      = '0;
        case (r_state)
            ST_IDLE:     o_in_ready = 1'b1;
            ST_RD_GAIN: begin
                rd_en   = 1'b1;
                rd_addr = rd_base + ADDR_W'(SLOT_GAIN);
            end
            ST_MUL_XG: begin
                rd_en   = 1'b1;
                rd_addr = rd_base + ADDR_W'(SLOT_BIAS);
                mul_a   = 33'(r_x);
                mul_b   = 18'(r_rd_data);
            end
            ST_ADD_BIAS: begin
                rd_en   = 1'b1;
                rd_addr = rd_base + ADDR_W'(SLOT_WOUT);
            end
            ST_SQ: begin
                mul_a = $signed({18'b0, r_t});
                mul_b = $signed({3'b0, r_t});
            end
            ST_MA1, ST_MA2: begin
                mul_a = $signed({1'b0, r_a});
                mul_b = $signed({1'b0, r_s});
            end
            ST_MB1, ST_MB2: begin
                mul_a = $signed({1'b0, r_b[31:0]});
                mul_b = $signed({1'b0, r_s});
            end
            ST_MTA: begin
                mul_a = $signed({1'b0, r_a});
                mul_b = $signed({1'b0, r_t, 2'b00});
            end
            ST_ACC_MUL: begin
                mul_a = 33'(r_tanh);
                mul_b = 18'(r_rd_data);
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_active    <= ACTIVE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_active <= i_cfg_wdata;
            end
            if (r_state == ST_EMIT && can_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // weight store
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_weight_value;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_x     <= i_sample_x;
                r_count <= count_cap;
                r_idx   <= '0;
                r_sum   <= '0;
            end
            ST_MUL_XG:   r_prod <= mul_p;
            ST_ADD_BIAS: r_u <= r_prod[31:0] + {{4{r_rd_data[15]}}, r_rd_data, 12'b0};
            ST_ABS: begin
                r_neg  <= r_u[31];
                r_mag  <= u_mag[25:0];
                r_tanh <= r_u[31] ? -$signed({1'b0, TANH_ONE}) : $signed({1'b0, TANH_ONE});
            end
            ST_T:        r_t <= 15'((27'(r_mag) + 27'd2048) >> 12);
            ST_SQ:       r_prod <= mul_p;
            ST_S:        r_s <= 17'((30'(r_prod[28:0]) + 30'd2048) >> 12);
            ST_INIT_AB: begin
                r_a <= 32'(r_s) + C378;
                r_b <= (34'(r_s) << 5) - (34'(r_s) << 2) + C3150;
            end
            ST_MA1, ST_MA2, ST_MB1, ST_MB2, ST_MTA, ST_ACC_MUL: r_prod <= mul_p;
            ST_MA1W:     r_a <= r_prod[43:12] + C17325;
            ST_MA2W:     r_a <= r_prod[43:12] + C135135;
            ST_MB1W:     r_b <= r_prod[45:12] + C62370;
            ST_MB2W:     r_b <= r_prod[45:12] + C135135W;
            ST_DIV_INIT: begin
                r_num  <= 49'(r_prod[47:0]) + 49'(r_b[33:1]);
                r_div  <= {r_b, 19'b0};
                r_q    <= '0;
                r_dcnt <= '0;
            end
            ST_DIV: begin
                if (div_ge) begin
                    r_num <= r_num - r_div[48:0];
                end
                r_q    <= {r_q[DIV_STEPS-2:0], div_ge};
                r_div  <= r_div >> 1;
                r_dcnt <= DCNT_W'(r_dcnt + 1'b1);
            end
            ST_CLAMP: begin
                r_tanh <= r_neg ? -$signed({1'b0, q_clamp}) : $signed({1'b0, q_clamp});
            end
            ST_ACC: begin
                r_sum <= r_sum + SUM_W'(r_prod);
                r_idx <= idx_inc;
            end
            ST_ROUND:    r_sum <= (r_sum + ROUND_HALF) >>> 14;
            ST_EMIT: begin
                if (can_emit) begin
                    if (r_sum > Y_MAX) begin
                        r_y   <= 16'sh7fff;
                        r_sat <= 1'b1;
                    end else if (r_sum < Y_MIN) begin
                        r_y   <= -16'sh8000;
                        r_sat <= 1'b1;
                    end else begin
                        r_y   <= 16'(r_sum);
                        r_sat <= 1'b0;
                    end
                end
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_result_y  = r_y;
    assign o_saturated = r_sat;

endmodule
`default_nettype wire

// File: tb/sv/one_input_tanh_mlp_inference_test.sv
`timescale 1ns / 1ps
// Self-checking bench for one_input_tanh_mlp_inference: weight loads and inferences
// driven over valid/ready and checked beat by beat against an in-bench Q4.12 predictor.
// Depends on tanh_mlp_pkg and the design top level.
module one_input_tanh_mlp_inference_test;
    import tanh_mlp_pkg::*;

    // No handshake or config write for this many cycles means the block is hung.
    // The worst legal gap is one 16-neuron inference plus the long output
    // hold below, so this leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_AT_RESULT = 40;     // long output stall starts after this result
    localparam int HOLD_CYCLES    = 1500;
    localparam int SETTLE_CYCLES  = 8;      // loads finish once accepted; small pad
    localparam int DRAIN_CYCLES   = 700;    // > longest inference, catches stray beats
    localparam int RESET_CYCLES   = 12;
    localparam longint Q12        = 4096;

    typedef struct packed {
        logic        action;
        logic [3:0]  neuron;
        logic [1:0]  slot;
        logic [15:0] weight;
        logic [15:0] x;
    } t_mlp_beat;

    typedef struct packed {
        logic [15:0] y;
        logic        sat;
    } t_mlp_result;

    // DUT-facing signals; all that the bench drives are known from time zero
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic        in_action = ACT_LOAD;
    logic [3:0]  in_neuron = '0;
    logic [1:0]  in_slot   = SLOT_GAIN;
    logic [15:0] in_weight = '0;
    logic [15:0] in_x      = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic signed [15:0] out_y;
    logic        out_sat;
    logic        cfg_we    = 1'b0;
    logic [4:0]  cfg_wdata = '0;

    // Predictor state: mirror of the weight store and of active_neurons
    logic signed [15:0] weight_mirror [DEPTH];
    logic [4:0]         neuron_count = ACTIVE_RESET;

    t_mlp_beat   queued_beats [$];      // waiting for the driver
    t_mlp_result predicted_outputs [$]; // one per accepted inference, oldest first
    t_mlp_beat   bus_beat;              // what the driver currently offers

    int beats_queued    = 0;
    int beats_accepted  = 0;
    int results_checked = 0;
    int mismatch_total  = 0;
    int hold_left       = 0;
    int idle_cycles     = 0;
    int send_idle_pct   = 12;
    int recv_idle_pct   = 76;

    one_input_tanh_mlp_inference dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_action       (in_action),
        .i_neuron_index (in_neuron),
        .i_weight_slot  (in_slot),
        .i_weight_value (in_weight),
        .i_sample_x     (in_x),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_result_y     (out_y),
        .o_saturated    (out_sat),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Rational tanh, u in Q.24, result Q1.14. The >>12 for t and s rounds,
    // the others truncate; flat at +-1.0 once |u| reaches 4.0.
    function automatic longint tanh_approx(input longint u);
        longint unsigned mag, t, s, a, b, q;
        mag = (u < 0) ? -u : u;
        if (mag >= (64'd4 << 24)) begin
            q = 64'd16384;
        end else begin
            t = (mag + 64'd2048) >> 12;
            s = (t * t + 64'd2048) >> 12;
            a = s + 64'd378 * Q12;
            b = 64'd28 * s + 64'd3150 * Q12;
            a = ((a * s) >> 12) + 64'd17325 * Q12;
            a = ((a * s) >> 12) + 64'd135135 * Q12;
            b = ((b * s) >> 12) + 64'd62370 * Q12;
            b = ((b * s) >> 12) + 64'd135135 * Q12;
            q = (64'd4 * t * a + b / 64'd2) / b;
            if (q > 64'd16384)
                q = 64'd16384;
        end
        return (u < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Full forward pass over the active neurons, rounded half up and clipped.
    function automatic t_mlp_result mlp_forward(input logic [15:0] x_bits);
        longint      x, u, acc, y;
        int          count;
        t_mlp_result r;
        x     = longint'($signed(x_bits));
        acc   = 0;
        count = (neuron_count > NEURONS) ? NEURONS : int'(neuron_count);
        for (int i = 0; i < count; i++) begin
            u = x * longint'(weight_mirror[3 * i + int'(SLOT_GAIN)])
                + longint'(weight_mirror[3 * i + int'(SLOT_BIAS)]) * Q12;
            acc += tanh_approx(u) * longint'(weight_mirror[3 * i + int'(SLOT_WOUT)]);
        end
        y = (acc + 8192) >>> 14;
        if (y > 32767) begin
            r.y   = 16'h7fff;
            r.sat = 1'b1;
        end else if (y < -32768) begin
            r.y   = 16'h8000;
            r.sat = 1'b1;
        end else begin
            r.y   = y[15:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: pops queued beats, holds each until accepted. At an accept
    // the predictor is updated first, then the next beat (or a gap) is put
    // on the bus in the same edge.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                beats_accepted++;
                if (bus_beat.action == ACT_INFER) begin
                    predicted_outputs.insert(predicted_outputs.size(),
                                             mlp_forward(bus_beat.x));
                end else if (bus_beat.slot != SLOT_UNUSED
                             && int'(bus_beat.neuron) < NEURONS) begin
                    // unused slot and out-of-store neuron loads are dropped
                    weight_mirror[3 * int'(bus_beat.neuron) + int'(bus_beat.slot)] =
                        $signed(bus_beat.weight);
                end
            end
            if (!in_valid || in_ready) begin
                if (queued_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    bus_beat   = queued_beats.pop_front();
                    in_valid  <= 1'b1;
                    in_action <= bus_beat.action;
                    in_neuron <= bus_beat.neuron;
                    in_slot   <= bus_beat.slot;
                    in_weight <= bus_beat.weight;
                    in_x      <= bus_beat.x;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks every output beat against the oldest prediction and
    // drives out_ready, including one long hold-off that backs the block up.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        t_mlp_result want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (predicted_outputs.size() == 0) begin
                    $error("output beat with no inference pending: y=%0d sat=%0b",
                           out_y, out_sat);
                    mismatch_total++;
                end else begin
                    want = predicted_outputs.pop_front();
                    if (out_y !== want.y) begin
                        $error("result_y: expected %0d, got %0d",
                               $signed(want.y), out_y);
                        mismatch_total++;
                    end
                    if (out_sat !== want.sat) begin
                        $error("saturated: expected %0b, got %0b", want.sat, out_sat);
                        mismatch_total++;
                    end
                end
                results_checked++;
                if (results_checked == HOLD_AT_RESULT)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: any handshake or config write counts as progress
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[one_input_tanh_mlp_inference] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Q4.12 value: 40% small (|v| <= 2.0, keeps tanh off its rails),
    // 15% corners, rest full range.
    function automatic logic [15:0] rand_q412();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40)
            return 16'($urandom_range(16384) - 8192);
        if (pick < 55) begin
            case ($urandom_range(3))
                0:       return 16'h8000;
                1:       return 16'h7fff;
                2:       return 16'h0000;
                default: return 16'hffff;
            endcase
        end
        return 16'($urandom);
    endfunction

    // Unused fields get random content so every input bit toggles.
    task automatic push_load(input int n, input logic [1:0] slot, input logic [15:0] w);
        t_mlp_beat b;
        b.action = ACT_LOAD;
        b.neuron = 4'(n);
        b.slot   = slot;
        b.weight = w;
        b.x      = 16'($urandom);
        queued_beats.insert(queued_beats.size(), b);
        beats_queued++;
    endtask

    task automatic push_infer(input logic [15:0] x);
        t_mlp_beat b;
        b.action = ACT_INFER;
        b.neuron = 4'($urandom);
        b.slot   = 2'($urandom);
        b.weight = 16'($urandom);
        b.x      = x;
        queued_beats.insert(queued_beats.size(), b);
        beats_queued++;
    endtask

    // Wait until every queued beat is taken and every prediction matched,
    // then let trailing loads finish.
    task automatic wait_idle(input int extra);
        @(negedge clk);
        while (beats_accepted != beats_queued || predicted_outputs.size() != 0)
            @(negedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_active(input int v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= 5'(v);
        @(posedge clk);
        cfg_we    <= 1'b0;
        neuron_count = 5'(v);
    endtask

    // One setting of active_neurons and one idling mode, random beats.
    task automatic random_phase(input int active, input int n_beats,
                                input int snd_pct, input int rcv_pct);
        t_mlp_beat b;
        int        used;
        write_active(active);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        used = (active > NEURONS) ? NEURONS : active;
        for (int k = 0; k < n_beats; k++) begin
            b.action = ($urandom_range(99) < 50) ? ACT_INFER : ACT_LOAD;
            // loads mostly land on neurons that the inferences actually use
            if (used != 0 && $urandom_range(9) < 7)
                b.neuron = 4'($urandom_range(used - 1));
            else
                b.neuron = 4'($urandom_range(15));
            b.slot   = ($urandom_range(19) == 0) ? SLOT_UNUSED : 2'($urandom_range(2));
            b.weight = rand_q412();
            b.x      = rand_q412();
            queued_beats.insert(queued_beats.size(), b);
            beats_queued++;
        end
        wait_idle(SETTLE_CYCLES);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part runs at the reset value of active_neurons (15).
        // Fill the whole store first: gain 1.0, bias 0, output weight ~8.0,
        // so no inference ever reads an unwritten entry.
        for (int n = 0; n < NEURONS; n++) begin
            push_load(n, SLOT_GAIN, 16'd4096);
            push_load(n, SLOT_BIAS, 16'd0);
            push_load(n, SLOT_WOUT, 16'h7fff);
        end
        push_infer(16'h0000);           // tanh(0): zero out
        push_infer(16'h7fff);           // x max: all rails, clips high
        push_infer(16'h8000);           // x min: clips low
        push_infer(16'd16384);          // |u| exactly 4.0: first saturated tanh
        push_infer(16'd16383);          // just below the rail: polynomial path
        push_infer(16'd41);             // small x, sum stays in range
        push_infer(16'hffff);           // smallest negative x
        // unused slot: load is dropped, result must match the x = 41 one above
        push_load(0, SLOT_UNUSED, 16'h8000);
        push_infer(16'd41);
        // weight extremes; neuron 15 sits beyond the 15 active ones
        push_load(0, SLOT_GAIN, 16'h8000);
        push_load(14, SLOT_BIAS, 16'h7fff);
        push_load(7, SLOT_WOUT, 16'h8000);
        push_load(15, SLOT_WOUT, 16'h0000);
        push_infer(16'd1000);
        push_infer(-16'sd20000);
        push_load(3, SLOT_BIAS, 16'h8000);
        push_infer(16'h0000);
        wait_idle(SETTLE_CYCLES);

        // Random part. Sender 12% / receiver 76% idle, then swapped, then none.
        // 31 acts as 16, 0 gives a zero result; most beats use few neurons.
        random_phase(16, 150, 12, 76);
        random_phase(1, 300, 12, 76);
        random_phase(4, 300, 76, 12);
        random_phase(31, 120, 76, 12);
        random_phase(0, 150, 0, 0);
        random_phase($urandom_range(8, 2), 400, 0, 0);
        random_phase(3, 380, 0, 0);

        wait_idle(DRAIN_CYCLES);
        if (mismatch_total == 0)
            $display("[one_input_tanh_mlp_inference] OK");
        else
            $display("[one_input_tanh_mlp_inference] ERROR");
        $finish;
    end

endmodule
